// ===== hw/rtl/route_penalized_cost_evaluator_assert.svh =====
// ---------------------------------------------------------------------------
// Route penalized cost evaluator assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ROUTE_PENALIZED_COST_EVALUATOR_ASSERT_SVH
`define ROUTE_PENALIZED_COST_EVALUATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPCE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rpce_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Route penalized cost evaluator package
// Widths, types and codes shared by the evaluator and its testbench.
// ---------------------------------------------------------------------------
package rpce_pkg;

	localparam int MAX_CLIENTS = 1024;
	localparam int CLIENT_W    = $clog2(MAX_CLIENTS);
	localparam int MAX_ROUTES  = 256;
	localparam int ROUTES_W    = $clog2(MAX_ROUTES + 1);
	localparam int EPOCH_W     = 12;

	localparam int TIME_W   = 24;
	localparam int DEMAND_W = 16;
	localparam int CAP_W    = 16;
	localparam int LIMIT_W  = 32;
	localparam int PEN_W    = 24;
	localparam int DIST_W   = 40;
	localparam int LOAD_W   = 32;
	localparam int CAPX_W   = 32;
	localparam int COST_W   = 63;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_W   = 8;
	localparam int SPLIT_W  = 20;
	localparam int HALF_PROD_W = SPLIT_W + PEN_W;
	localparam int PROD_W   = DIST_W + PEN_W;
	localparam int P1_W     = CAPX_W + PEN_W;
	localparam int P2_W     = PROD_W - FRAC_W;

	localparam logic [LIMIT_W-1:0] DURATION_LIMIT_RESET = '1;

	typedef logic [CLIENT_W-1:0]        client_t;
	typedef logic [EPOCH_W-1:0]         epoch_t;
	typedef logic [ROUTES_W-1:0]        routes_t;
	typedef logic [TIME_W-1:0]          time_t;
	typedef logic [DIST_W-1:0]          dist_t;
	typedef logic [DIST_W:0]            dist1_t;
	typedef logic [DIST_W+1:0]          dist2_t;
	typedef logic signed [LOAD_W-1:0]   load_t;
	typedef logic signed [LOAD_W:0]     load1_t;
	typedef logic [CAPX_W-1:0]          capx_t;
	typedef logic [CAPX_W:0]            capx1_t;
	typedef logic [COST_W-1:0]          cost_t;
	typedef logic [PROD_W-1:0]          prod_t;
	typedef logic [HALF_PROD_W-1:0]     half_prod_t;
	typedef logic [P1_W-1:0]            p1_t;
	typedef logic [P2_W-1:0]            p2_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY,
		CFG_DUR_LIMIT,
		CFG_CAP_PENALTY,
		CFG_DUR_PENALTY
	} cfg_index_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

endpackage

// ===== hw/rtl/rpce_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rpce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/route_penalized_cost_evaluator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Route penalized cost evaluator
// Evaluates a routing solution streamed one visit per item and reports its
// distance, excesses, penalized cost and feasibility at solution end.
// ---------------------------------------------------------------------------
// The input channel takes one visit per item, route by route; an item with
// last_in_solution set also closes its route and produces one result item on
// the output channel. Other items produce no result. The block takes one item
// per clock cycle while in_stall is low.
// Visited clients are kept in a 1024 by 12 RAM tagged with a route number, so
// a new route needs no clearing. After reset, and again after every 4095
// routes when the route number runs out, a clearing pass writes the whole RAM,
// during which in_stall is high.
// The user must write configuration registers through wr_en, wr_index and
// wr_data only while the block is idle; the block leaves this unchecked.
// When out_stall holds a finished result, later items still enter and move
// through the pipeline; only a second result waiting behind the held one
// stops the pipeline and raises in_stall until the output is taken.
// ---------------------------------------------------------------------------
`include "route_penalized_cost_evaluator_assert.svh"

module route_penalized_cost_evaluator (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rpce_pkg::CLIENT_W-1:0]        client,
	input  logic [rpce_pkg::CLIENT_W-1:0]        pickup_partner,
	input  logic signed [rpce_pkg::DEMAND_W-1:0] demand,
	input  logic [rpce_pkg::TIME_W-1:0]          service_time,
	input  logic [rpce_pkg::TIME_W-1:0]          leg_distance,
	input  logic [rpce_pkg::TIME_W-1:0]          return_distance,
	input  logic                                 last_in_route,
	input  logic                                 last_in_solution,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [rpce_pkg::DIST_W-1:0]          total_distance,
	output logic [rpce_pkg::ROUTES_W-1:0]        route_count,
	output logic [rpce_pkg::CAPX_W-1:0]          capacity_excess,
	output logic [rpce_pkg::DIST_W-1:0]          duration_excess,
	output logic [rpce_pkg::COST_W-1:0]          penalized_cost,
	output logic                                 order_feasible,
	output logic                                 load_feasible,
	output logic                                 feasible,

	input  logic                                 wr_en,
	input  logic [rpce_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [rpce_pkg::CFG_W-1:0]           wr_data
);

	localparam rpce_pkg::routes_t ROUTES_MAX = rpce_pkg::ROUTES_W'(rpce_pkg::MAX_ROUTES);
	localparam rpce_pkg::client_t CLR_LAST = rpce_pkg::CLIENT_W'(rpce_pkg::MAX_CLIENTS - 1);

	// Configuration registers.
	logic [rpce_pkg::CAP_W-1:0]   capacity_q;
	logic [rpce_pkg::LIMIT_W-1:0] limit_q;
	logic [rpce_pkg::PEN_W-1:0]   cap_pen_q;
	logic [rpce_pkg::PEN_W-1:0]   dur_pen_q;

	// Control.
	rpce_pkg::state_t  state_q, state_d;
	rpce_pkg::client_t clr_addr_q;
	rpce_pkg::epoch_t  epoch_q;
	logic              route_open_q;
	logic              adv;
	logic              accept;
	logic              close_in;
	logic              clearing;
	logic              clr_done;

	// Visited store.
	logic              ram_we;
	rpce_pkg::client_t ram_waddr;
	rpce_pkg::epoch_t  ram_wdata;
	rpce_pkg::epoch_t  ram_rdata;

	// Route and solution accumulators.
	rpce_pkg::dist_t   route_dist_q;
	rpce_pkg::dist_t   route_svc_q;
	rpce_pkg::load_t   route_load_q;
	logic              prec_q;
	logic              capok_q;
	rpce_pkg::dist_t   sum_dist_q;
	rpce_pkg::routes_t routes_q;
	rpce_pkg::capx_t   sum_cap_q;
	rpce_pkg::dist_t   sum_dur_q;

	// Stage 1.
	logic              v_s1;
	rpce_pkg::client_t client_s1;
	rpce_pkg::client_t partner_s1;
	logic signed [rpce_pkg::DEMAND_W-1:0] demand_s1;
	rpce_pkg::time_t   svc_s1;
	rpce_pkg::time_t   leg_s1;
	rpce_pkg::time_t   ret_s1;
	logic              start_s1;
	logic              close_s1;
	logic              last_s1;
	rpce_pkg::epoch_t  epoch_s1;
	logic              prec_fail;
	logic              prec_next;
	rpce_pkg::dist1_t  rd_sum;
	rpce_pkg::dist1_t  rs_sum;
	rpce_pkg::dist_t   rd_new;
	rpce_pkg::dist_t   rs_new;
	rpce_pkg::load_t   load_base;
	rpce_pkg::load1_t  load_sum;
	rpce_pkg::load_t   load_new;

	// Stage 2.
	logic              v_s2;
	rpce_pkg::dist_t   rd_s2;
	rpce_pkg::dist_t   rs_s2;
	rpce_pkg::load_t   load_s2;
	rpce_pkg::time_t   ret_s2;
	logic              close_s2;
	logic              last_s2;
	logic              prec_s2;
	rpce_pkg::dist1_t  rt_sum;
	rpce_pkg::dist_t   rt_new;
	rpce_pkg::load1_t  load_diff;
	logic              load_over;
	logic              capok_next;
	rpce_pkg::capx_t   capx_new;

	// Stage 3.
	logic              v_s3;
	rpce_pkg::dist_t   rt_s3;
	rpce_pkg::dist_t   rs_s3;
	rpce_pkg::capx_t   capx_s3;
	logic              close_s3;
	logic              last_s3;
	logic              prec_s3;
	logic              capok_s3;
	rpce_pkg::dist_t   rt_add;
	rpce_pkg::dist1_t  dist_sum;
	rpce_pkg::dist_t   dist_new;
	rpce_pkg::capx1_t  cap_sum;
	rpce_pkg::capx_t   cap_new;
	rpce_pkg::routes_t routes_new;
	rpce_pkg::dist1_t  dur_new;

	// Stage 4.
	logic              v_s4;
	rpce_pkg::dist_t   dist_s4;
	rpce_pkg::routes_t routes_s4;
	rpce_pkg::capx_t   capsum_s4;
	rpce_pkg::dist1_t  dur_s4;
	logic              close_s4;
	logic              last_s4;
	logic              prec_s4;
	logic              capok_s4;
	rpce_pkg::dist2_t  dur_diff;
	logic              dur_over;
	rpce_pkg::dist1_t  durx_new;

	// Stage 5.
	logic              v_s5;
	rpce_pkg::dist_t   dist_s5;
	rpce_pkg::routes_t routes_s5;
	rpce_pkg::capx_t   capsum_s5;
	rpce_pkg::dist1_t  durx_s5;
	logic              last_s5;
	logic              prec_s5;
	logic              capok_s5;
	rpce_pkg::dist2_t  dur_sum;
	rpce_pkg::dist_t   dursum_new;
	rpce_pkg::p1_t     p1_new;

	// Stage 6.
	logic              v_s6;
	rpce_pkg::dist_t   dist_s6;
	rpce_pkg::routes_t routes_s6;
	rpce_pkg::capx_t   capsum_s6;
	rpce_pkg::dist_t   dursum_s6;
	rpce_pkg::p1_t     p1_s6;
	logic              prec_s6;
	logic              capok_s6;

	// Stage 7.
	logic                 v_s7;
	rpce_pkg::dist_t      dist_s7;
	rpce_pkg::routes_t    routes_s7;
	rpce_pkg::capx_t      capsum_s7;
	rpce_pkg::dist_t      dursum_s7;
	rpce_pkg::p1_t        p1_s7;
	rpce_pkg::half_prod_t lo_s7;
	rpce_pkg::half_prod_t hi_s7;
	logic                 prec_s7;
	logic                 capok_s7;
	logic                 feas_s7;
	rpce_pkg::prod_t      prod_full;

	// Stage 8.
	logic              v_s8;
	rpce_pkg::dist_t   dist_s8;
	rpce_pkg::routes_t routes_s8;
	rpce_pkg::capx_t   capsum_s8;
	rpce_pkg::dist_t   dursum_s8;
	rpce_pkg::cost_t   part_s8;
	rpce_pkg::p2_t     p2_s8;
	logic              prec_s8;
	logic              capok_s8;
	logic              feas_s8;

	logic              out_valid_q;

	// ---------------------------------------------------------------------
	// Configuration
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			limit_q    <= rpce_pkg::DURATION_LIMIT_RESET;
			cap_pen_q  <= '0;
			dur_pen_q  <= '0;
		end else if (wr_en) begin
			case (rpce_pkg::cfg_index_t'(wr_index))
				rpce_pkg::CFG_CAPACITY:    capacity_q <= wr_data[rpce_pkg::CAP_W-1:0];
				rpce_pkg::CFG_DUR_LIMIT:   limit_q    <= wr_data[rpce_pkg::LIMIT_W-1:0];
				rpce_pkg::CFG_CAP_PENALTY: cap_pen_q  <= wr_data[rpce_pkg::PEN_W-1:0];
				rpce_pkg::CFG_DUR_PENALTY: dur_pen_q  <= wr_data[rpce_pkg::PEN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Handshake, clearing pass and route tags
	// ---------------------------------------------------------------------
	assign adv      = !(v_s8 && out_valid_q && out_stall);
	assign clearing = (state_q == rpce_pkg::ST_CLEAR);
	assign clr_done = clearing && (clr_addr_q == CLR_LAST);
	assign in_stall = !adv || clearing;
	assign accept   = in_valid && !in_stall;
	assign close_in = last_in_route || last_in_solution;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rpce_pkg::ST_CLEAR: begin
				if (clr_done) begin
					state_d = rpce_pkg::ST_RUN;
				end
			end
			rpce_pkg::ST_RUN: begin
				if (accept && close_in && (epoch_q == '1)) begin
					state_d = rpce_pkg::ST_CLEAR;
				end
			end
			default: state_d = rpce_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpce_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			epoch_q      <= rpce_pkg::EPOCH_W'(1);
			route_open_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (clr_done) begin
				epoch_q <= rpce_pkg::EPOCH_W'(1);
			end else if (accept && close_in) begin
				epoch_q <= epoch_q + 1'b1;
			end
			if (accept) begin
				route_open_q <= !close_in;
			end
		end
	end

	assign ram_we    = clearing || accept;
	assign ram_waddr = clearing ? clr_addr_q : client;
	assign ram_wdata = clearing ? '0 : epoch_q;

	rpce_ram #(
		.WIDTH (rpce_pkg::EPOCH_W),
		.DEPTH (rpce_pkg::MAX_CLIENTS)
	) u_visited (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (pickup_partner),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------------
	// Stage 1: precedence check and route sums
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			client_s1  <= client;
			partner_s1 <= pickup_partner;
			demand_s1  <= demand;
			svc_s1     <= service_time;
			leg_s1     <= leg_distance;
			ret_s1     <= return_distance;
			start_s1   <= !route_open_q;
			close_s1   <= close_in;
			last_s1    <= last_in_solution;
			epoch_s1   <= epoch_q;
		end
	end

	always_comb begin
		prec_fail = (partner_s1 != '0) && (ram_rdata != epoch_s1) && (partner_s1 != client_s1);
		prec_next = prec_q && !prec_fail;
		rd_sum    = rpce_pkg::dist1_t'(start_s1 ? '0 : route_dist_q) + rpce_pkg::dist1_t'(leg_s1);
		rs_sum    = rpce_pkg::dist1_t'(start_s1 ? '0 : route_svc_q) + rpce_pkg::dist1_t'(svc_s1);
		rd_new    = rd_sum[rpce_pkg::DIST_W] ? '1 : rd_sum[rpce_pkg::DIST_W-1:0];
		rs_new    = rs_sum[rpce_pkg::DIST_W] ? '1 : rs_sum[rpce_pkg::DIST_W-1:0];
		load_base = start_s1 ? '0 : route_load_q;
		load_sum  = rpce_pkg::load1_t'(load_base) + rpce_pkg::load1_t'(demand_s1);
		if (load_sum[rpce_pkg::LOAD_W] != load_sum[rpce_pkg::LOAD_W-1]) begin
			load_new = load_sum[rpce_pkg::LOAD_W] ?
				{1'b1, {(rpce_pkg::LOAD_W-1){1'b0}}} : {1'b0, {(rpce_pkg::LOAD_W-1){1'b1}}};
		end else begin
			load_new = load_sum[rpce_pkg::LOAD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_dist_q <= '0;
			route_svc_q  <= '0;
			route_load_q <= '0;
			prec_q       <= 1'b1;
			v_s2         <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				route_dist_q <= rd_new;
				route_svc_q  <= rs_new;
				route_load_q <= load_new;
				prec_q       <= last_s1 ? 1'b1 : prec_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			rd_s2    <= rd_new;
			rs_s2    <= rs_new;
			load_s2  <= load_new;
			ret_s2   <= ret_s1;
			close_s2 <= close_s1;
			last_s2  <= last_s1;
			prec_s2  <= prec_next;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: return leg and load against capacity
	// ---------------------------------------------------------------------
	always_comb begin
		rt_sum     = rpce_pkg::dist1_t'(rd_s2) + rpce_pkg::dist1_t'(ret_s2);
		rt_new     = rt_sum[rpce_pkg::DIST_W] ? '1 : rt_sum[rpce_pkg::DIST_W-1:0];
		load_diff  = rpce_pkg::load1_t'(load_s2) - rpce_pkg::load1_t'(capacity_q);
		load_over  = !load_diff[rpce_pkg::LOAD_W] && (load_diff != '0);
		capok_next = capok_q && !load_over;
		capx_new   = (close_s2 && load_over) ? load_diff[rpce_pkg::CAPX_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capok_q <= 1'b1;
			v_s3    <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			if (v_s2) begin
				capok_q <= last_s2 ? 1'b1 : capok_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			rt_s3    <= rt_new;
			rs_s3    <= rs_s2;
			capx_s3  <= capx_new;
			close_s3 <= close_s2;
			last_s3  <= last_s2;
			prec_s3  <= prec_s2;
			capok_s3 <= capok_next;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: distance, route count and capacity excess sums
	// ---------------------------------------------------------------------
	always_comb begin
		rt_add     = close_s3 ? rt_s3 : '0;
		dist_sum   = rpce_pkg::dist1_t'(sum_dist_q) + rpce_pkg::dist1_t'(rt_add);
		dist_new   = dist_sum[rpce_pkg::DIST_W] ? '1 : dist_sum[rpce_pkg::DIST_W-1:0];
		cap_sum    = rpce_pkg::capx1_t'(sum_cap_q) + rpce_pkg::capx1_t'(capx_s3);
		cap_new    = cap_sum[rpce_pkg::CAPX_W] ? '1 : cap_sum[rpce_pkg::CAPX_W-1:0];
		routes_new = (close_s3 && (routes_q != ROUTES_MAX)) ? routes_q + 1'b1 : routes_q;
		dur_new    = rpce_pkg::dist1_t'(rt_s3) + rpce_pkg::dist1_t'(rs_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_dist_q <= '0;
			sum_cap_q  <= '0;
			routes_q   <= '0;
			v_s4       <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
			if (v_s3) begin
				sum_dist_q <= last_s3 ? '0 : dist_new;
				sum_cap_q  <= last_s3 ? '0 : cap_new;
				routes_q   <= last_s3 ? '0 : routes_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			dist_s4   <= dist_new;
			routes_s4 <= routes_new;
			capsum_s4 <= cap_new;
			dur_s4    <= dur_new;
			close_s4  <= close_s3;
			last_s4   <= last_s3;
			prec_s4   <= prec_s3;
			capok_s4  <= capok_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: duration against limit
	// ---------------------------------------------------------------------
	always_comb begin
		dur_diff = rpce_pkg::dist2_t'(dur_s4) - rpce_pkg::dist2_t'(limit_q);
		dur_over = !dur_diff[rpce_pkg::DIST_W+1] && (dur_diff != '0);
		durx_new = (close_s4 && dur_over) ? dur_diff[rpce_pkg::DIST_W:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4) begin
			dist_s5   <= dist_s4;
			routes_s5 <= routes_s4;
			capsum_s5 <= capsum_s4;
			durx_s5   <= durx_new;
			last_s5   <= last_s4;
			prec_s5   <= prec_s4;
			capok_s5  <= capok_s4;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: duration excess sum and capacity penalty product
	// ---------------------------------------------------------------------
	always_comb begin
		dur_sum    = rpce_pkg::dist2_t'(sum_dur_q) + rpce_pkg::dist2_t'(durx_s5);
		dursum_new = (dur_sum[rpce_pkg::DIST_W+1:rpce_pkg::DIST_W] != '0) ?
			'1 : dur_sum[rpce_pkg::DIST_W-1:0];
		p1_new     = capsum_s5 * cap_pen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_dur_q <= '0;
			v_s6      <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5 && last_s5;
			if (v_s5) begin
				sum_dur_q <= last_s5 ? '0 : dursum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s5) begin
			dist_s6   <= dist_s5;
			routes_s6 <= routes_s5;
			capsum_s6 <= capsum_s5;
			dursum_s6 <= dursum_new;
			p1_s6     <= p1_new;
			prec_s6   <= prec_s5;
			capok_s6  <= capok_s5;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 6: duration penalty partial products
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s6) begin
			dist_s7   <= dist_s6;
			routes_s7 <= routes_s6;
			capsum_s7 <= capsum_s6;
			dursum_s7 <= dursum_s6;
			p1_s7     <= p1_s6;
			lo_s7     <= dursum_s6[rpce_pkg::SPLIT_W-1:0] * dur_pen_q;
			hi_s7     <= dursum_s6[rpce_pkg::DIST_W-1:rpce_pkg::SPLIT_W] * dur_pen_q;
			prec_s7   <= prec_s6;
			capok_s7  <= capok_s6;
			feas_s7   <= (capsum_s6 == '0) && (dursum_s6 == '0) && prec_s6 && capok_s6;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 7: product assembly and partial cost
	// ---------------------------------------------------------------------
	assign prod_full = (rpce_pkg::prod_t'(hi_s7) << rpce_pkg::SPLIT_W) + rpce_pkg::prod_t'(lo_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s7) begin
			dist_s8   <= dist_s7;
			routes_s8 <= routes_s7;
			capsum_s8 <= capsum_s7;
			dursum_s8 <= dursum_s7;
			part_s8   <= rpce_pkg::cost_t'(dist_s7) + rpce_pkg::cost_t'(p1_s7);
			p2_s8     <= prod_full[rpce_pkg::PROD_W-1:rpce_pkg::FRAC_W];
			prec_s8   <= prec_s7;
			capok_s8  <= capok_s7;
			feas_s8   <= feas_s7;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 8: final cost into the output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s8 && adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s8 && adv) begin
			total_distance  <= dist_s8;
			route_count     <= routes_s8;
			capacity_excess <= capsum_s8;
			duration_excess <= dursum_s8;
			penalized_cost  <= part_s8 + rpce_pkg::cost_t'(p2_s8);
			order_feasible  <= prec_s8;
			load_feasible   <= capok_s8;
			feasible        <= feas_s8;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`RPCE_ASSERT_NOW(a_epoch_live, state_q == rpce_pkg::ST_RUN, epoch_q != '0,
		"route tag is zero while items are taken")
	`RPCE_ASSERT_NEXT(a_result_held, v_s8 && !adv, v_s8,
		"held result left the last stage without reaching the output")
	`RPCE_ASSERT_NOW(a_route_bound, out_valid_q, route_count <= ROUTES_MAX,
		"route count above its limit")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Route penalized cost evaluator testbench
// Streams routing solutions into the evaluator one visit per item. A short
// table of directed visits comes first, then random solutions under several
// register settings and idling patterns. The testbench keeps its own model of
// the route and solution sums, predicts every solution report and compares it,
// or the table's own report, field by field with what the block delivers.
// ---------------------------------------------------------------------------
module tb;
	import rpce_pkg::*;

	localparam int HALF_PERIOD    = 2;
	localparam int RESET_CYCLES   = 11;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 40;
	localparam int LONG_ROUTES    = MAX_ROUTES + 4;
	localparam int DIRECTED_ROWS  = 13;

	localparam logic [63:0] DIST_MAX = 64'h0000_00FF_FFFF_FFFF;
	localparam logic [63:0] CAPX_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] COST_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint      LOAD_HI  = 2147483647;
	localparam longint      LOAD_LO  = -LOAD_HI - 1;

	typedef struct packed {
		client_t             client;
		client_t             partner;
		logic [DEMAND_W-1:0] demand;
		time_t               service;
		time_t               leg;
		time_t               ret;
		logic                last_route;
		logic                last_sol;
	} visit_t;

	typedef struct packed {
		dist_t   total_distance;
		routes_t route_count;
		capx_t   capacity_excess;
		dist_t   duration_excess;
		cost_t   penalized_cost;
		logic    order_feasible;
		logic    load_feasible;
		logic    feasible;
	} report_t;

	typedef struct packed {
		visit_t  visit;
		logic    typed;
		report_t report;
	} directed_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	client_t             client;
	client_t             pickup_partner;
	logic [DEMAND_W-1:0] demand;
	time_t               service_time;
	time_t               leg_distance;
	time_t               return_distance;
	logic                last_in_route;
	logic                last_in_solution;
	logic                out_valid;
	logic                out_stall = 1'b0;
	dist_t               total_distance;
	routes_t             route_count;
	capx_t               capacity_excess;
	dist_t               duration_excess;
	cost_t               penalized_cost;
	logic                order_feasible;
	logic                load_feasible;
	logic                feasible;
	logic                wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]    wr_data;

	// Model state of the evaluator and shadows of its registers.
	bit                 visited [MAX_CLIENTS];
	dist_t              route_dist;
	dist_t              route_service;
	longint             route_load;
	dist_t              sum_dist;
	capx_t              sum_capx;
	dist_t              sum_durx;
	routes_t            routes_done;
	bit                 route_active;
	bit                 order_ok;
	bit                 load_ok;
	logic [CAP_W-1:0]   capacity;
	logic [LIMIT_W-1:0] dur_limit;
	logic [PEN_W-1:0]   cap_weight;
	logic [PEN_W-1:0]   dur_weight;

	report_t pending_reports [$];
	int      mismatch_count = 0;
	int      quiet_cycles = 0;
	int      item_count = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{'{10'd1, 10'd0, 16'h0000, 24'h0, 24'h100, 24'h200, 1'b1, 1'b1}, 1'b1,
			'{40'h300, 9'd1, 32'd0, 40'd0, 63'h300, 1'b1, 1'b1, 1'b1}},
		'{'{10'd1023, 10'd1023, 16'h8000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1},
			1'b1, '{40'h1FFFFFE, 9'd1, 32'd0, 40'd0, 63'h1FFFFFE, 1'b1, 1'b1, 1'b1}},
		'{'{10'd5, 10'd7, 16'h7FFF, 24'h0, 24'h0, 24'h0, 1'b1, 1'b1}, 1'b1,
			'{40'd0, 9'd1, 32'd32767, 40'd0, 63'd0, 1'b0, 1'b0, 1'b0}},
		'{'{10'd0, 10'd0, 16'h0001, 24'h10, 24'h20, 24'h30, 1'b0, 1'b0}, 1'b0, '0},
		'{'{10'd2, 10'd0, 16'hFFFF, 24'h0, 24'h40, 24'h50, 1'b1, 1'b0}, 1'b0, '0},
		'{'{10'd3, 10'd0, 16'h0005, 24'h11, 24'h22, 24'h33, 1'b0, 1'b0}, 1'b0, '0},
		'{'{10'd4, 10'd3, 16'hFFFB, 24'h44, 24'h55, 24'h66, 1'b0, 1'b0}, 1'b0, '0},
		'{'{10'd6, 10'd2, 16'h0000, 24'h77, 24'h88, 24'h99, 1'b1, 1'b0}, 1'b0, '0},
		'{'{10'd8, 10'd0, 16'h0002, 24'h100, 24'h200, 24'h300, 1'b0, 1'b1}, 1'b0, '0},
		'{'{10'h2AA, 10'h155, 16'h5555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0, 1'b0},
			1'b0, '0},
		'{'{10'h155, 10'h2AA, 16'hAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 1'b0, 1'b0},
			1'b0, '0},
		'{'{10'h3FF, 10'h200, 16'h0000, 24'h1, 24'h2, 24'h3, 1'b1, 1'b0}, 1'b0, '0},
		'{'{10'd9, 10'd9, 16'h0003, 24'h4, 24'h5, 24'h6, 1'b1, 1'b1}, 1'b0, '0}
	};

	route_penalized_cost_evaluator u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.client           (client),
		.pickup_partner   (pickup_partner),
		.demand           (demand),
		.service_time     (service_time),
		.leg_distance     (leg_distance),
		.return_distance  (return_distance),
		.last_in_route    (last_in_route),
		.last_in_solution (last_in_solution),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.total_distance   (total_distance),
		.route_count      (route_count),
		.capacity_excess  (capacity_excess),
		.duration_excess  (duration_excess),
		.penalized_cost   (penalized_cost),
		.order_feasible   (order_feasible),
		.load_feasible    (load_feasible),
		.feasible         (feasible),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [63:0] clip_sum(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] max);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, max}) ? max : s[63:0];
	endfunction

	// Advances the model by one visit and returns 1 when it ends a solution.
	function automatic bit evaluate_visit(input visit_t v, output report_t r);
		logic [63:0] dur;
		logic [63:0] weighted_cap;
		logic [63:0] weighted_dur;
		logic [63:0] cost;
		r = '0;
		if (!route_active) begin
			foreach (visited[i]) visited[i] = 1'b0;
			route_dist = '0;
			route_service = '0;
			route_load = 0;
			route_active = 1'b1;
		end
		visited[v.client] = 1'b1;
		if (v.partner != '0 && !visited[v.partner])
			order_ok = 1'b0;
		route_dist = dist_t'(clip_sum(route_dist, v.leg, DIST_MAX));
		route_service = dist_t'(clip_sum(route_service, v.service, DIST_MAX));
		route_load += longint'($signed(v.demand));
		if (route_load > LOAD_HI)
			route_load = LOAD_HI;
		if (route_load < LOAD_LO)
			route_load = LOAD_LO;
		if (route_load > longint'(capacity))
			load_ok = 1'b0;
		if (v.last_route || v.last_sol) begin
			route_dist = dist_t'(clip_sum(route_dist, v.ret, DIST_MAX));
			sum_dist = dist_t'(clip_sum(sum_dist, route_dist, DIST_MAX));
			if (routes_done < MAX_ROUTES)
				routes_done++;
			if (route_load > longint'(capacity))
				sum_capx = capx_t'(clip_sum(sum_capx,
					64'(route_load - longint'(capacity)), CAPX_MAX));
			dur = 64'(route_dist) + 64'(route_service);
			if (dur > 64'(dur_limit))
				sum_durx = dist_t'(clip_sum(sum_durx, dur - 64'(dur_limit), DIST_MAX));
			route_active = 1'b0;
		end
		if (!v.last_sol)
			return 1'b0;
		weighted_cap = 64'(sum_capx) * 64'(cap_weight);
		weighted_dur = (64'(sum_durx) * 64'(dur_weight)) >> FRAC_W;
		cost = clip_sum(clip_sum(sum_dist, weighted_cap, COST_MAX), weighted_dur, COST_MAX);
		r.total_distance = sum_dist;
		r.route_count = routes_done;
		r.capacity_excess = sum_capx;
		r.duration_excess = sum_durx;
		r.penalized_cost = cost_t'(cost);
		r.order_feasible = order_ok;
		r.load_feasible = load_ok;
		r.feasible = sum_capx == '0 && sum_durx == '0 && order_ok && load_ok;
		sum_dist = '0;
		sum_capx = '0;
		sum_durx = '0;
		routes_done = '0;
		order_ok = 1'b1;
		load_ok = 1'b1;
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Presents one visit and returns at the edge that accepts it.
	task automatic send_visit(input visit_t v, input logic typed = 1'b0,
			input report_t want = '0);
		report_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		client <= v.client;
		pickup_partner <= v.partner;
		demand <= v.demand;
		service_time <= v.service;
		leg_distance <= v.leg;
		return_distance <= v.ret;
		last_in_route <= v.last_route;
		last_in_solution <= v.last_sol;
		do @(posedge clk); while (in_stall);
		if (evaluate_visit(v, predicted))
			pending_reports.push_back(typed ? want : predicted);
	endtask

	task automatic drain_results(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		case (idx)
			CFG_CAPACITY:    capacity = value[CAP_W-1:0];
			CFG_DUR_LIMIT:   dur_limit = value[LIMIT_W-1:0];
			CFG_CAP_PENALTY: cap_weight = value[PEN_W-1:0];
			CFG_DUR_PENALTY: dur_weight = value[PEN_W-1:0];
		endcase
	endtask

	task automatic apply_settings(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] limit,
			input logic [CFG_W-1:0] cap_pen, input logic [CFG_W-1:0] dur_pen);
		write_reg(CFG_CAPACITY, cap);
		write_reg(CFG_DUR_LIMIT, limit);
		write_reg(CFG_CAP_PENALTY, cap_pen);
		write_reg(CFG_DUR_PENALTY, dur_pen);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic time_t random_duration();
		if ($urandom_range(7) == 0)
			return time_t'($urandom);
		return time_t'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic visit_t random_visit();
		visit_t v;
		v.client = client_t'($urandom_range(0, MAX_CLIENTS - 1));
		v.partner = client_t'($urandom);
		v.demand = DEMAND_W'($urandom);
		v.service = random_duration();
		v.leg = random_duration();
		v.ret = random_duration();
		v.last_route = 1'b1 & $urandom_range(1);
		v.last_sol = ($urandom_range(15) == 0);
		return v;
	endfunction

	// Mostly pickups followed by their deliveries in the same route, with a share
	// of scrambled visits that break precedence or end routes or solutions at random.
	task automatic run_solution(input int route_total, input int max_len, input int noise_pct);
		client_t in_route [$];
		client_t earlier [$];
		visit_t  v;
		int      len;
		int      dmax;
		for (int r = 0; r < route_total; r++) begin
			len = $urandom_range(1, max_len);
			in_route.delete();
			for (int k = 0; k < len; k++) begin
				v = random_visit();
				dmax = int'(capacity) / 2 + 2;
				if (dmax > 32767)
					dmax = 32767;
				if ($urandom_range(99) >= noise_pct) begin
					if (in_route.size() != 0 && $urandom_range(1) == 1) begin
						v.partner = in_route[$urandom_range(in_route.size() - 1)];
						v.demand = DEMAND_W'(-int'($urandom_range(1, dmax)));
					end else begin
						v.partner = '0;
						v.demand = DEMAND_W'($urandom_range(1, dmax));
					end
					v.last_route = (k == len - 1);
					v.last_sol = 1'b0;
				end else if (earlier.size() != 0 && $urandom_range(1) == 1) begin
					v.partner = earlier[$urandom_range(earlier.size() - 1)];
				end
				if (r == route_total - 1 && k == len - 1) begin
					v.last_sol = 1'b1;
					if ($urandom_range(5) == 0)
						v.last_route = 1'b0;
				end
				in_route.push_back(v.client);
				earlier.push_back(v.client);
				send_visit(v);
				item_count++;
			end
		end
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_reports.size() == 0) begin
				flag_mismatch("result with none expected", total_distance, '0);
			end else begin
				want = pending_reports.pop_front();
				if (total_distance !== want.total_distance)
					flag_mismatch("total_distance", total_distance, want.total_distance);
				if (route_count !== want.route_count)
					flag_mismatch("route_count", route_count, want.route_count);
				if (capacity_excess !== want.capacity_excess)
					flag_mismatch("capacity_excess", capacity_excess, want.capacity_excess);
				if (duration_excess !== want.duration_excess)
					flag_mismatch("duration_excess", duration_excess, want.duration_excess);
				if (penalized_cost !== want.penalized_cost)
					flag_mismatch("penalized_cost", penalized_cost, want.penalized_cost);
				if (order_feasible !== want.order_feasible)
					flag_mismatch("order_feasible", order_feasible, want.order_feasible);
				if (load_feasible !== want.load_feasible)
					flag_mismatch("load_feasible", load_feasible, want.load_feasible);
				if (feasible !== want.feasible)
					flag_mismatch("feasible", feasible, want.feasible);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int phase_start;
		bit paused;
		paused = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		client = '0;
		pickup_partner = '0;
		demand = '0;
		service_time = '0;
		leg_distance = '0;
		return_distance = '0;
		last_in_route = 1'b0;
		last_in_solution = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		route_dist = '0;
		route_service = '0;
		route_load = 0;
		sum_dist = '0;
		sum_capx = '0;
		sum_durx = '0;
		routes_done = '0;
		route_active = 1'b0;
		order_ok = 1'b1;
		load_ok = 1'b1;
		capacity = '0;
		dur_limit = DURATION_LIMIT_RESET;
		cap_weight = '0;
		dur_weight = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_visit(directed_rows[i].visit, directed_rows[i].typed, directed_rows[i].report);
		drain_results(SETTLE_CYCLES);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_settings(32'h0, 32'h0, 32'hFF_FFFF, 32'hFF_FFFF);
				1: apply_settings(32'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
				default: apply_settings(
					($urandom_range(1) == 1) ? $urandom_range(0, 400) : $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 32'h0008_0000),
					$urandom_range(0, 24'hFF_FFFF),
					$urandom_range(0, 24'hFF_FFFF));
			endcase
			send_idle_pct = (phase % 4 == 1) ? 64 : (phase % 4 == 3) ? 27 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 64 : (phase % 4 == 3) ? 27 : 0;
			if (phase == 2)
				run_solution(LONG_ROUTES, 1, 0);
			phase_start = item_count;
			while (item_count - phase_start < PHASE_ITEMS) begin
				run_solution($urandom_range(1, 5), 6, 10);
				if (!paused || $urandom_range(3) == 0) begin
					drain_results(0);
					paused = 1'b1;
				end
			end
			drain_results(SETTLE_CYCLES);
		end

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
